>>> src/ptwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptwa_pkg
// Shared widths, codes and types for the peak tracker with average.
// ----------------------------------------------------------------------------
package ptwa_pkg;

    localparam int CUR_W      = 27;   // signed current value
    localparam int CODE_W     = 10;   // converter code
    localparam int GAIN_W     = 16;   // unsigned gain
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CURRENT = 2'd2;

    // commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // register reset values
    localparam logic [CODE_W-1:0] ZERO_CODE_RST = 10'd512;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd256;

    typedef logic signed [CUR_W-1:0] cur_t;

endpackage
`default_nettype wire

>>> src/top_peak_tracker_with_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_peak_tracker_with_average
// Keeps the largest currents seen and reports lowest kept peak and mean.
// ----------------------------------------------------------------------------
// Input beat: command (sample or clear) and a 10-bit converter code. The code
// is turned into (code - zero_code) * gain and, when the store has room or
// the value beats the smallest kept peak, written into the slot memory.
// Every input beat gives one output beat: below_threshold, peak_count,
// lowest_peak and average_peak.
// Configuration beats (cfg_index, cfg_data) are always taken; write them only
// while the block is idle. Index 3 is ignored.
// in_ready rises with out_valid. The longer of the bit-serial divider for
// the mean and the rescan of the slot memory for a new minimum sets how long
// a sample takes; at 16 slots the divider. A beat that leaves the store
// empty (a clear) skips the divide.
// One item is worked on at a time; in_ready is high when no item is in
// flight, even while a result waits on the output.
// If the receiver stalls, a finished result is held in the output register
// and the next result waits until that beat is taken.
// Reset empties the store and loads zero_code 512, gain 256, min_current 0.
// ----------------------------------------------------------------------------
module top_peak_tracker_with_average #(
    parameter int PEAK_SLOTS = 16,
    localparam int CNT_W = $clog2(PEAK_SLOTS + 1)
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // configuration
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ptwa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [ptwa_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input items
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 command,
    input  wire  [ptwa_pkg::CODE_W-1:0]         sample,
    // results
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                below_threshold,
    output logic [CNT_W-1:0]                    peak_count,
    output logic signed [ptwa_pkg::CUR_W-1:0]   lowest_peak,
    output logic signed [ptwa_pkg::CUR_W-1:0]   average_peak
);
    import ptwa_pkg::*;

    localparam int IDX_W  = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
    localparam int SUM_W  = CUR_W + CNT_W;
    localparam int DIV_CW = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_START,
        S_WORK,
        S_DONE
    } state_t;

    state_t                    state_reg;

    // configuration registers
    logic [CODE_W-1:0]         zero_code_reg;
    logic [GAIN_W-1:0]         gain_reg;
    cur_t                      min_current_reg;

    // item in flight
    logic                      cmd_reg;
    logic signed [CODE_W:0]    diff_reg;
    cur_t                      cur_reg;
    logic                      below_reg;

    // tracker state
    logic [CNT_W-1:0]          count_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [IDX_W-1:0]          low_slot_reg;
    cur_t                      low_val_reg;

    // rescan
    logic                      scan_req_reg;
    logic [CNT_W-1:0]          issue_reg;
    logic                      rd_valid_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    cur_t                      rd_data_reg;
    cur_t                      best_val_reg;
    logic [IDX_W-1:0]          best_idx_reg;

    // serial divider
    logic [DIV_CW-1:0]         div_cnt_reg;
    logic [SUM_W-1:0]          dq_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic                      neg_reg;

    // output register
    logic                      out_valid_reg;
    logic                      out_below_reg;
    logic [CNT_W-1:0]          out_count_reg;
    cur_t                      out_lowest_reg;
    cur_t                      out_avg_reg;

    // slot memory
    cur_t                      mem [PEAK_SLOTS];

    logic signed [CUR_W:0]     prod;
    logic                      full;
    logic signed [SUM_W-1:0]   cur_ext;
    logic signed [SUM_W-1:0]   low_ext;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      scan_done;
    logic                      div_done;
    logic [CNT_W:0]            trial;
    logic                      q_bit;
    logic [CNT_W:0]            rem_step;
    logic [SUM_W-1:0]          sum_mag;
    logic [SUM_W-1:0]          avg_full;

    assign cfg_ready       = 1'b1;
    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign below_threshold = out_below_reg;
    assign peak_count      = out_count_reg;
    assign lowest_peak     = out_lowest_reg;
    assign average_peak    = out_avg_reg;

    assign prod    = (CUR_W + 1)'(diff_reg) * (CUR_W + 1)'($signed({1'b0, gain_reg}));
    assign full    = (count_reg == CNT_W'(PEAK_SLOTS));
    assign cur_ext = {{(SUM_W - CUR_W){cur_reg[CUR_W-1]}}, cur_reg};
    assign low_ext = {{(SUM_W - CUR_W){low_val_reg[CUR_W-1]}}, low_val_reg};

    // append while there is room, otherwise replace the smallest kept peak
    assign wr_en   = (state_reg == S_UPD) && (cmd_reg == CMD_SAMPLE)
                     && (!full || (cur_reg > low_val_reg));
    assign wr_addr = full ? low_slot_reg : count_reg[IDX_W-1:0];

    assign rd_en   = (state_reg == S_WORK) && scan_req_reg
                     && (issue_reg != CNT_W'(PEAK_SLOTS));
    assign rd_addr = issue_reg[IDX_W-1:0];

    assign scan_done = !scan_req_reg
                       || ((issue_reg == CNT_W'(PEAK_SLOTS)) && !rd_valid_reg);
    assign div_done  = (div_cnt_reg == '0);

    // restoring divide step: one quotient bit per cycle
    assign trial    = {rem_reg, dq_reg[SUM_W-1]};
    assign q_bit    = (trial >= {1'b0, count_reg});
    assign rem_step = q_bit ? (trial - {1'b0, count_reg}) : trial;

    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign avg_full = neg_reg ? (~dq_reg + SUM_W'(1)) : dq_reg;

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cur_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            zero_code_reg   <= ZERO_CODE_RST;
            gain_reg        <= GAIN_RST;
            min_current_reg <= '0;
            cmd_reg         <= CMD_SAMPLE;
            diff_reg        <= '0;
            cur_reg         <= '0;
            below_reg       <= 1'b0;
            count_reg       <= '0;
            sum_reg         <= '0;
            low_slot_reg    <= '0;
            low_val_reg     <= '0;
            scan_req_reg    <= 1'b0;
            issue_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            best_val_reg    <= '0;
            best_idx_reg    <= '0;
            div_cnt_reg     <= '0;
            dq_reg          <= '0;
            rem_reg         <= '0;
            neg_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_below_reg   <= 1'b0;
            out_count_reg   <= '0;
            out_lowest_reg  <= '0;
            out_avg_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ZERO_CODE:   zero_code_reg   <= cfg_data[CODE_W-1:0];
                    CFG_GAIN:        gain_reg        <= cfg_data[GAIN_W-1:0];
                    CFG_MIN_CURRENT: min_current_reg <= cfg_data[CUR_W-1:0];
                    default:         ;
                endcase
            end

            // S_DONE reloads the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= command;
                        diff_reg  <= $signed({1'b0, sample})
                                     - $signed({1'b0, zero_code_reg});
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    cur_reg   <= prod[CUR_W-1:0];
                    state_reg <= S_UPD;
                end

                S_UPD:
                begin
                    scan_req_reg <= 1'b0;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        below_reg    <= 1'b0;
                        count_reg    <= '0;
                        sum_reg      <= '0;
                        low_slot_reg <= '0;
                        low_val_reg  <= '0;
                    end
                    else
                    begin
                        below_reg <= (cur_reg < min_current_reg);
                        if (!full)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            sum_reg   <= sum_reg + cur_ext;
                            if ((count_reg == '0) || (cur_reg < low_val_reg))
                            begin
                                low_slot_reg <= count_reg[IDX_W-1:0];
                                low_val_reg  <= cur_reg;
                            end
                        end
                        else if (cur_reg > low_val_reg)
                        begin
                            sum_reg      <= sum_reg + cur_ext - low_ext;
                            scan_req_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_START;
                end

                S_START:
                begin
                    issue_reg    <= '0;
                    rd_valid_reg <= 1'b0;
                    neg_reg      <= sum_reg[SUM_W-1];
                    dq_reg       <= sum_mag;
                    rem_reg      <= '0;
                    div_cnt_reg  <= (count_reg == '0) ? '0 : DIV_CW'(SUM_W);
                    state_reg    <= S_WORK;
                end

                S_WORK:
                begin
                    // rescan: issue one read a cycle, compare the data in the next cycle
                    rd_valid_reg <= rd_en;
                    rd_idx_reg   <= rd_addr;
                    if (rd_en)
                    begin
                        issue_reg <= issue_reg + CNT_W'(1);
                    end
                    if (rd_valid_reg
                        && ((rd_idx_reg == '0) || (rd_data_reg < best_val_reg)))
                    begin
                        best_val_reg <= rd_data_reg;
                        best_idx_reg <= rd_idx_reg;
                    end

                    if (!div_done)
                    begin
                        dq_reg      <= {dq_reg[SUM_W-2:0], q_bit};
                        rem_reg     <= rem_step[CNT_W-1:0];
                        div_cnt_reg <= div_cnt_reg - DIV_CW'(1);
                    end

                    if (scan_done && div_done)
                    begin
                        if (scan_req_reg)
                        begin
                            low_slot_reg <= best_idx_reg;
                            low_val_reg  <= best_val_reg;
                        end
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_below_reg  <= below_reg;
                        out_count_reg  <= count_reg;
                        out_lowest_reg <= (count_reg == '0) ? '0 : low_val_reg;
                        out_avg_reg    <= (count_reg == '0) ? '0
                                                            : avg_full[CUR_W-1:0];
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the peak tracker with average.
// ----------------------------------------------------------------------------
// A task-level tracker keeps its own copy of the peak store and registers and
// predicts one result beat per input beat. Result beats are compared field by
// field, in order, against the oldest prediction. Traffic is a short directed
// set, then phases under extreme and random register settings, with random
// idling on both channels and a full drain before each register write.
// ----------------------------------------------------------------------------
module testbench;
    import ptwa_pkg::*;

    localparam int PEAK_SLOTS  = 16;
    localparam int CNT_W       = $clog2(PEAK_SLOTS + 1);
    localparam int PHASE_ITEMS = 100;
    localparam int STALL_LIMIT = 3000;
    localparam int REPORT_MAX  = 10;
    localparam int DRAIN_TAIL  = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [CFG_DATA_W-1:0] CUR_MAX_RAW = 27'h3FF_FFFF;
    localparam logic [CFG_DATA_W-1:0] CUR_MIN_RAW = 27'h400_0000;

    typedef struct packed {
        logic             below;
        logic [CNT_W-1:0] count;
        cur_t             lowest;
        cur_t             mean;
    } peak_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  command;
    logic [CODE_W-1:0]     sample;
    logic                  out_valid;
    logic                  out_ready;
    logic                  below_threshold;
    logic [CNT_W-1:0]      peak_count;
    cur_t                  lowest_peak;
    cur_t                  average_peak;

    // tracker copy of the block
    logic [CODE_W-1:0] trk_zero_code;
    logic [GAIN_W-1:0] trk_gain;
    cur_t              trk_min_current;
    cur_t              trk_peaks [PEAK_SLOTS];
    int                trk_count;
    int                trk_low;

    peak_report_t pending_reports[$];
    int           mismatches;
    int           quiet_cycles;
    int           send_idle_pct;
    int           recv_idle_pct;

    top_peak_tracker_with_average #(
        .PEAK_SLOTS (PEAK_SLOTS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .below_threshold (below_threshold),
        .peak_count      (peak_count),
        .lowest_peak     (lowest_peak),
        .average_peak    (average_peak)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // tracker
    // ------------------------------------------------------------------
    function automatic void clear_peaks();
        int i;
        for (i = 0; i < PEAK_SLOTS; i++)
        begin
            trk_peaks[i] = '0;
        end
        trk_count = 0;
        trk_low   = 0;
    endfunction

    function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ZERO_CODE:   trk_zero_code = data[CODE_W-1:0];
            CFG_GAIN:        trk_gain = data[GAIN_W-1:0];
            CFG_MIN_CURRENT: trk_min_current = $signed(data);
            default: ;
        endcase
    endfunction

    // Advance the tracker by one accepted beat and queue the report it gives.
    function automatic void track_peaks(input logic cmd, input logic [CODE_W-1:0] code);
        longint       current;
        longint       total;
        int           i;
        peak_report_t rep;
        rep = '0;
        if (cmd == CMD_CLEAR)
        begin
            clear_peaks();
        end
        else
        begin
            current   = (longint'(code) - longint'(trk_zero_code)) * longint'(trk_gain);
            rep.below = (current < longint'(trk_min_current));
            if (trk_count < PEAK_SLOTS)
            begin
                trk_peaks[trk_count] = cur_t'(current);
                if (trk_count != 0 && current < longint'(trk_peaks[trk_low]))
                begin
                    trk_low = trk_count;
                end
                trk_count++;
            end
            else if (current > longint'(trk_peaks[trk_low]))
            begin
                // overwrite the smallest, then rescan; first index wins ties
                trk_peaks[trk_low] = cur_t'(current);
                trk_low = 0;
                for (i = 1; i < PEAK_SLOTS; i++)
                begin
                    if (trk_peaks[i] < trk_peaks[trk_low])
                    begin
                        trk_low = i;
                    end
                end
            end
        end
        if (trk_count != 0)
        begin
            total = 0;
            for (i = 0; i < trk_count; i++)
            begin
                total += longint'(trk_peaks[i]);
            end
            rep.lowest = trk_peaks[trk_low];
            rep.mean   = cur_t'(total / longint'(trk_count));
        end
        rep.count = trk_count[CNT_W-1:0];
        pending_reports.push_back(rep);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("%t mismatch: %s", $realtime, msg);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        peak_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                flag_mismatch("result beat with no prediction waiting");
            end
            else
            begin
                want = pending_reports.pop_front();
                if (below_threshold !== want.below)
                begin
                    flag_mismatch($sformatf("below_threshold exp %0b got %0b",
                                            want.below, below_threshold));
                end
                if (peak_count !== want.count)
                begin
                    flag_mismatch($sformatf("peak_count exp %0d got %0d",
                                            want.count, peak_count));
                end
                if (lowest_peak !== want.lowest)
                begin
                    flag_mismatch($sformatf("lowest_peak exp %0d got %0d",
                                            $signed(want.lowest), lowest_peak));
                end
                if (average_peak !== want.mean)
                begin
                    flag_mismatch($sformatf("average_peak exp %0d got %0d",
                                            $signed(want.mean), average_peak));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // end the run when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // drivers; every task starts and ends on a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [CODE_W-1:0] code);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        sample   <= code;
        do
            @(posedge clk);
        while (!in_ready);
        track_peaks(cmd, code);
        @(negedge clk);
    endtask

    // Hold the input side until every predicted result has been taken.
    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        set_register(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] zc, input logic [CFG_DATA_W-1:0] gn,
                             input logic [CFG_DATA_W-1:0] mc, input bit poke_unused);
        wait_results();
        write_reg(CFG_ZERO_CODE, zc);
        write_reg(CFG_GAIN, gn);
        write_reg(CFG_MIN_CURRENT, mc);
        if (poke_unused)
        begin
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly samples clustered around a center, so the store fills, ties
    // appear and replacement runs; a few clears and wide-range codes mixed in.
    task automatic run_samples();
        int center;
        int spread;
        int code;
        int k;
        center = $urandom_range(1023);
        spread = $urandom_range(15);
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            if ($urandom_range(99) < 3)
            begin
                send_item(CMD_CLEAR, CODE_W'($urandom_range(1023)));
            end
            else if ($urandom_range(99) < 70)
            begin
                code = center - spread + $urandom_range(2 * spread);
                if (code < 0)
                begin
                    code = 0;
                end
                if (code > 1023)
                begin
                    code = 1023;
                end
                send_item(CMD_SAMPLE, code[CODE_W-1:0]);
            end
            else
            begin
                send_item(CMD_SAMPLE, CODE_W'($urandom_range(1023)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        // empty store, then the code extremes and the zero point
        send_item(CMD_CLEAR, '1);
        send_item(CMD_SAMPLE, 10'd0);
        send_item(CMD_SAMPLE, 10'd1023);
        send_item(CMD_SAMPLE, 10'd512);
    endtask

    task automatic test_store_replacement();
        int codes [PEAK_SLOTS] = '{20, 5, 9, 5, 30, 12, 5, 40, 7, 25, 18, 5, 33, 11, 16, 22};
        int i;
        configure(27'd0, 27'd1, 27'd10, 1'b0);
        send_item(CMD_CLEAR, '0);
        for (i = 0; i < PEAK_SLOTS; i++)
        begin
            send_item(CMD_SAMPLE, codes[i][CODE_W-1:0]);
        end
        send_item(CMD_SAMPLE, 10'd5);     // equal to smallest: drop
        send_item(CMD_SAMPLE, 10'd6);     // replace, rescan finds a tie
        send_item(CMD_SAMPLE, 10'd1023);  // replace again
        send_item(CMD_CLEAR, '0);
    endtask

    task automatic test_config_extremes();
        send_idle_pct = 18;
        recv_idle_pct = 63;
        configure({17'd0, ZERO_CODE_RST}, {11'd0, GAIN_RST}, '0, 1'b1);
        run_samples();
        configure(27'd0, 27'hFFFF, CUR_MAX_RAW, 1'b0);
        run_samples();
        configure(27'd1023, 27'hFFFF, CUR_MIN_RAW, 1'b0);
        run_samples();
        // zero gain: every current is zero, so every value ties
        configure(CFG_DATA_W'($urandom()), 27'd0, 27'd1, 1'b1);
        run_samples();
    endtask

    task automatic test_random_configs();
        int p;
        for (p = 0; p < 6; p++)
        begin
            if (p == 0)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 18;
            end
            else if (p == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                      CFG_DATA_W'($urandom()), (p % 2) == 0);
            run_samples();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ZERO_CODE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = CMD_SAMPLE;
        sample        = '0;
        out_ready     = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 18;
        recv_idle_pct = 63;
        trk_zero_code = ZERO_CODE_RST;
        trk_gain      = GAIN_RST;
        trk_min_current = '0;
        clear_peaks();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_store_replacement();
        test_config_extremes();
        test_random_configs();

        wait_results();
        repeat (DRAIN_TAIL) @(negedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
